>>> design/line_command_matcher_heartbeat_assert.svh
// Assertion macros used by the checker file.
`ifndef LINE_COMMAND_MATCHER_HEARTBEAT_ASSERT_SVH
`define LINE_COMMAND_MATCHER_HEARTBEAT_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define LCMH_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("lcmh assertion failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define LCMH_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("lcmh assertion failed");

`endif

>>> design/lcmh_pkg.sv
`timescale 1ns / 1ps

package lcmh_pkg;

  localparam int unsigned POS_W = 4;

  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [15:0] TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] TICKS_MAX = 16'hFFFF;
  localparam logic [POS_W-1:0] CONNECTED_LEN = 4'd9;
  localparam logic [POS_W-1:0] STARTROOT_LEN = 4'd10;

  localparam logic ACTION_BYTE = 1'b0;
  localparam logic ACTION_TICK = 1'b1;

  typedef enum logic {
    PAT_CONNECTED,
    PAT_STARTROOT
  } pat_sel_t;

  typedef struct packed {
    logic fire;
    logic mode;
    logic ready;
    logic tick;
    logic line_connected;
    logic line_startroot;
  } wd_cmd_t;

  typedef struct packed {
    logic root_switch;
    logic not_ready_notice;
    logic node_fallback;
  } wd_res_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0B) || (c == 8'h0C);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
  endfunction

  function automatic logic [POS_W-1:0] pat_len(input pat_sel_t sel);
    return (sel == PAT_CONNECTED) ? CONNECTED_LEN : STARTROOT_LEN;
  endfunction

  function automatic logic [7:0] pat_char(input pat_sel_t sel, input logic [POS_W-1:0] pos);
    logic [7:0] ch;
    ch = 8'h00;
    if (sel == PAT_CONNECTED) begin
      unique case (pos)
        4'd0: ch = "c";
        4'd1: ch = "o";
        4'd2: ch = "n";
        4'd3: ch = "n";
        4'd4: ch = "e";
        4'd5: ch = "c";
        4'd6: ch = "t";
        4'd7: ch = "e";
        4'd8: ch = "d";
        default: ch = 8'h00;
      endcase
    end else begin
      unique case (pos)
        4'd0: ch = "s";
        4'd1: ch = "t";
        4'd2: ch = "a";
        4'd3: ch = "r";
        4'd4: ch = "t";
        4'd5: ch = " ";
        4'd6: ch = "r";
        4'd7: ch = "o";
        4'd8: ch = "o";
        4'd9: ch = "t";
        default: ch = 8'h00;
      endcase
    end
    return ch;
  endfunction

endpackage

>>> design/lcmh_matcher.sv
`timescale 1ns / 1ps

module lcmh_matcher import lcmh_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pat_sel_t   pat_sel,
  input  logic       clear,
  input  logic       step,
  input  logic [7:0] ch,
  output logic       hit
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             alive_r, alive_nxt;
  logic [POS_W-1:0] len;

  assign len = pat_len(pat_sel);
  assign hit = alive_r && (pos_r == len);

  always_comb begin
    pos_nxt   = pos_r;
    alive_nxt = alive_r;
    if (clear) begin
      pos_nxt   = '0;
      alive_nxt = 1'b1;
    end else if (step && alive_r) begin
      if (pos_r < len) begin
        if (fold(ch) == pat_char(pat_sel, pos_r)) begin
          pos_nxt = pos_r + 1'b1;
        end else begin
          alive_nxt = 1'b0;
        end
      end else if (!is_blank(ch)) begin
        alive_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      alive_r <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      alive_r <= alive_nxt;
    end
  end

endmodule

>>> design/lcmh_watchdog.sv
`timescale 1ns / 1ps

module lcmh_watchdog import lcmh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] timeout,
  input  wd_cmd_t     cmd,
  output wd_res_t     res
);

  logic        armed_r, armed_nxt;
  logic        pending_r, pending_nxt;
  logic [15:0] ticks_r, ticks_nxt;

  always_comb begin
    armed_nxt   = armed_r;
    pending_nxt = pending_r;
    ticks_nxt   = ticks_r;
    res         = '0;
    if (!cmd.mode) begin
      armed_nxt = 1'b0;
    end else begin
      if (pending_r && cmd.ready) begin
        res.root_switch = 1'b1;
        armed_nxt       = 1'b1;
        ticks_nxt       = '0;
        pending_nxt     = 1'b0;
      end
      if (cmd.tick) begin
        if (ticks_nxt != TICKS_MAX) begin
          ticks_nxt = ticks_nxt + 16'd1;
        end
        if (armed_nxt && (ticks_nxt > timeout)) begin
          res.node_fallback = 1'b1;
          armed_nxt         = 1'b0;
          ticks_nxt         = '0;
        end
      end else if (cmd.line_connected) begin
        ticks_nxt = '0;
      end else if (cmd.line_startroot) begin
        if (cmd.ready) begin
          res.root_switch = 1'b1;
          armed_nxt       = 1'b1;
          ticks_nxt       = '0;
          pending_nxt     = 1'b0;
        end else begin
          pending_nxt          = 1'b1;
          res.not_ready_notice = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r   <= 1'b0;
      pending_r <= 1'b0;
      ticks_r   <= '0;
    end else if (cmd.fire) begin
      armed_r   <= armed_nxt;
      pending_r <= pending_nxt;
      ticks_r   <= ticks_nxt;
    end
  end

endmodule

>>> design/line_command_matcher_heartbeat.sv
`timescale 1ns / 1ps

// Channel | Ports                                   | Direction
// in      | in_valid in_ready in_action in_rx_byte  | word in
//         | in_mesh_mode in_mesh_ready              |
// out     | out_valid out_ready out_heartbeat_seen  | word out
//         | out_root_switch out_not_ready_notice    |
//         | out_unknown_command out_node_fallback   |
// cfg     | cfg_valid cfg_ready cfg_data            | word in
//
// One word is accepted every cycle unless the output stalls; its result is registered.
// The rate is set by the input register and the result register, with the line,
// matcher and watchdog update in the single logic stage between them.
// A stalled output holds the result register and then the input register.
// Reset sets the timeout to 1000, clears the line, the pending request and the
// watchdog; the configuration port is always ready.

module line_command_matcher_heartbeat import lcmh_pkg::*; #(
  parameter int unsigned LINE_MAX = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_mesh_mode,
  input  logic        in_mesh_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_heartbeat_seen,
  output logic        out_root_switch,
  output logic        out_not_ready_notice,
  output logic        out_unknown_command,
  output logic        out_node_fallback,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int unsigned LEN_W = $clog2(LINE_MAX);
  localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_MAX - 1);

  logic             item_v_r;
  logic             action_r;
  logic [7:0]       byte_r;
  logic             mode_r;
  logic             ready_r;
  logic [15:0]      timeout_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic             started_r, started_nxt;
  logic             out_valid_r;
  logic             hb_r, rs_r, nr_r, unk_r, nf_r;

  logic    fire;
  logic    is_byte;
  logic    term;
  logic    full;
  logic    nonempty_end;
  logic    m_clear;
  logic    m_step;
  logic    conn_hit;
  logic    sr_hit;
  wd_cmd_t wd_cmd;
  wd_res_t wd_res;

  assign fire      = item_v_r && (!out_valid_r || out_ready);
  assign in_ready  = !item_v_r || fire;
  assign cfg_ready = 1'b1;

  assign is_byte      = mode_r && (action_r == ACTION_BYTE);
  assign term         = (byte_r == CHAR_CR) || (byte_r == CHAR_LF);
  assign full         = (len_r >= LEN_FULL);
  assign nonempty_end = is_byte && term && (len_r != '0);
  assign m_clear      = fire && (!mode_r || (is_byte && (term || full)));
  assign m_step       = fire && is_byte && !term && !full && (started_r || !is_blank(byte_r));

  always_comb begin
    len_nxt     = len_r;
    started_nxt = started_r;
    if (m_clear) begin
      len_nxt     = '0;
      started_nxt = 1'b0;
    end else if (fire && is_byte) begin
      len_nxt = len_r + 1'b1;
      if (m_step) begin
        started_nxt = 1'b1;
      end
    end
  end

  lcmh_matcher u_conn (
    .clk     (clk),
    .rst_n   (rst_n),
    .pat_sel (PAT_CONNECTED),
    .clear   (m_clear),
    .step    (m_step),
    .ch      (byte_r),
    .hit     (conn_hit)
  );

  lcmh_matcher u_sroot (
    .clk     (clk),
    .rst_n   (rst_n),
    .pat_sel (PAT_STARTROOT),
    .clear   (m_clear),
    .step    (m_step),
    .ch      (byte_r),
    .hit     (sr_hit)
  );

  always_comb begin
    wd_cmd                = '0;
    wd_cmd.fire           = fire;
    wd_cmd.mode           = mode_r;
    wd_cmd.ready          = ready_r;
    wd_cmd.tick           = (action_r == ACTION_TICK);
    wd_cmd.line_connected = nonempty_end && conn_hit;
    wd_cmd.line_startroot = nonempty_end && !conn_hit && sr_hit;
  end

  lcmh_watchdog u_wd (
    .clk     (clk),
    .rst_n   (rst_n),
    .timeout (timeout_r),
    .cmd     (wd_cmd),
    .res     (wd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      timeout_r   <= TIMEOUT_RST;
      len_r       <= '0;
      started_r   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
      if (in_valid && in_ready) begin
        item_v_r <= 1'b1;
      end else if (fire) begin
        item_v_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      len_r     <= len_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      action_r <= in_action;
      byte_r   <= in_rx_byte;
      mode_r   <= in_mesh_mode;
      ready_r  <= in_mesh_ready;
    end
    if (fire) begin
      hb_r  <= nonempty_end && conn_hit;
      rs_r  <= wd_res.root_switch;
      nr_r  <= wd_res.not_ready_notice;
      unk_r <= nonempty_end && !conn_hit && !sr_hit;
      nf_r  <= wd_res.node_fallback;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_heartbeat_seen   = hb_r;
  assign out_root_switch      = rs_r;
  assign out_not_ready_notice = nr_r;
  assign out_unknown_command  = unk_r;
  assign out_node_fallback    = nf_r;

endmodule

>>> design/lcmh_checker.sv
`timescale 1ns / 1ps

`include "line_command_matcher_heartbeat_assert.svh"

module lcmh_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_heartbeat_seen,
  input logic        out_root_switch,
  input logic        out_not_ready_notice,
  input logic        out_unknown_command,
  input logic        out_node_fallback
);

  // A stalled result stays offered.
  `LCMH_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // The input side only stalls when a result is waiting on the output.
  `LCMH_ASSERT_NOW(a_in_stall, !in_ready, out_valid && !out_ready)

  // A recognized heartbeat line is neither unknown nor a root request.
  `LCMH_ASSERT_NOW(a_hb_excl, out_valid && out_heartbeat_seen,
    !out_unknown_command && !out_not_ready_notice)

  // A not-ready notice means the mesh was not ready, so no switch and no other line result.
  `LCMH_ASSERT_NOW(a_nr_excl, out_valid && out_not_ready_notice,
    !out_root_switch && !out_unknown_command && !out_node_fallback)

endmodule

bind line_command_matcher_heartbeat lcmh_checker u_lcmh_checker (.*);
